// File: src/pcpc_pkg.sv
// Shared types, constants and codes of the phase current pair conditioner.
`default_nettype none
package pcpc_pkg;

   localparam int ADC_BITS      = 12;
   localparam int OUT_FRAC_BITS = 16;
   localparam int GAIN_FRAC     = 24;
   localparam int ALPHA_FRAC    = 16;
   localparam int FILT_FRAC     = 16;
   localparam int OFFSET_W      = 20;
   localparam int GAIN_W        = 32;
   localparam int ALPHA_W       = 17;
   localparam int OUT_W         = 32;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ALPHA_W-1:0]  ALPHA_ONE    = ALPHA_W'(1 << ALPHA_FRAC);
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1 << (OFFSET_W - 1));
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(1 << GAIN_FRAC);

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;
   localparam int CUR_W  = 42;

   localparam int DIV_W      = 48;
   localparam int DIV_DIGITS = 8;
   localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_U     = 3'd0,
      CSR_OFFSET_V     = 3'd1,
      CSR_OFFSET_W     = 3'd2,
      CSR_CURRENT_GAIN = 3'd3,
      CSR_VOLTAGE_GAIN = 3'd4,
      CSR_FILTER_ALPHA = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_NEW,
      ST_FILT_OLD,
      ST_FILT_RND,
      ST_GAIN_MUL,
      ST_GAIN_RND,
      ST_MEAN_START,
      ST_MEAN_WAIT,
      ST_DELTA_MUL,
      ST_DELTA_START,
      ST_DELTA_WAIT,
      ST_VBUS_MUL,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] raw_u;
      logic [ADC_BITS-1:0] raw_v;
      logic [ADC_BITS-1:0] raw_w;
      logic [ADC_BITS-1:0] raw_vbus;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] current_u;
      logic signed [OUT_W-1:0] current_v;
      logic signed [OUT_W-1:0] current_w;
      logic signed [OUT_W-1:0] delta_u;
      logic signed [OUT_W-1:0] delta_v;
      logic signed [OUT_W-1:0] delta_w;
      logic [OUT_W-1:0]        bus_voltage;
      logic [OUT_W-1:0]        update_count;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage
`default_nettype wire

// File: src/pcpc_div3.sv
// Unsigned divide-by-three unit that retires eight dividend bits per cycle.
`default_nettype none
module pcpc_div3 (
   input  logic                  clock,
   input  logic                  reset,
   input  pcpc_pkg::div_req_type div_req,
   output pcpc_pkg::div_rsp_type div_rsp
);

   localparam logic [2:0] DIVISOR = 3'd3;

   logic                               busy_ff;
   logic                               done_ff;
   logic [pcpc_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [pcpc_pkg::DIV_W-1:0]         dvd_ff;
   logic [pcpc_pkg::DIV_W-1:0]         quo_ff;
   logic [1:0]                         rem_ff;
   logic [1:0]                         rem_in;
   logic [pcpc_pkg::DIV_DIGITS-1:0]    qbits_in;

   always_comb begin : digit_steps
      logic [2:0] trial;
      logic [1:0] rem;
      rem = rem_ff;
      qbits_in = '0;
      for (int i = 0; i < pcpc_pkg::DIV_DIGITS; i++) begin
         trial = {rem, dvd_ff[pcpc_pkg::DIV_W-1-i]};
         if (trial >= DIVISOR) begin
            qbits_in[pcpc_pkg::DIV_DIGITS-1-i] = 1'b1;
            rem = 2'(trial - DIVISOR);
         end else begin
            rem = trial[1:0];
         end
      end
      rem_in = rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == pcpc_pkg::DIV_CNT_W'(pcpc_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         dvd_ff <= div_req.dividend;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << pcpc_pkg::DIV_DIGITS;
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[pcpc_pkg::DIV_W-pcpc_pkg::DIV_DIGITS-1:0], qbits_in};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
`default_nettype wire

// File: src/phase_current_pair_conditioner_unit.sv
// Phase current pair conditioner: offset removal, IIR filter, gain and common-mode removal.
// The req channel takes one conversion set per beat (three phase currents and the bus
// voltage). The first beat of a pair is only stored. The second beat starts a sequence
// on one shared 33x33 multiplier and a divide-by-three unit that ends in one beat on the
// rsp channel: filter and gain work for each phase, the three-phase mean, each phase
// delta and the bus voltage, in that order. The mean and each delta take the divider's
// six digit steps. No new beat is taken before the sequence is back in its idle state.
// req_ready is high only while the sequencer waits in its idle state.
// The result waits in an output register; the next pair's first beat is accepted while it
// waits, but a finished result is held until the receiver has taken the previous one.
// Registers on the csr port are written at any edge with csr_we high and should be
// changed only while the block is idle. Reset restores the register defaults, clears the
// filter state, the stored first set, the pair phase and the result counter.
`default_nettype none
module phase_current_pair_conditioner_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  pcpc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output pcpc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [pcpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pcpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int ADC   = pcpc_pkg::ADC_BITS;
   localparam int MW    = pcpc_pkg::MUL_W;
   localparam int PW    = pcpc_pkg::PROD_W;
   localparam int CW    = pcpc_pkg::CUR_W;
   localparam int DW    = pcpc_pkg::DIV_W;
   localparam int OW    = pcpc_pkg::OUT_W;
   localparam int AVG_W = ADC + 9;
   localparam int DNUM_W = ADC + 4;
   localparam int CUR_SH = pcpc_pkg::FILT_FRAC + pcpc_pkg::GAIN_FRAC - pcpc_pkg::OUT_FRAC_BITS;
   localparam int DELTA_SH = pcpc_pkg::GAIN_FRAC - pcpc_pkg::OUT_FRAC_BITS;
   localparam int DELTA_HALF = (3 << DELTA_SH) / 2;
   localparam int VBUS_SH = pcpc_pkg::GAIN_FRAC + 1 - pcpc_pkg::OUT_FRAC_BITS;

   function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] x,
                                                        input int sh);
      logic [PW-1:0] mag;
      mag = x[PW-1] ? PW'(-x) : PW'(x);
      mag = (mag + (PW'(1) << (sh - 1))) >> sh;
      return x[PW-1] ? -signed'(mag) : signed'(mag);
   endfunction

   function automatic logic signed [OW-1:0] sat32(input logic signed [PW-1:0] x);
      if ((&x[PW-1:OW-1]) || !(|x[PW-1:OW-1])) begin
         return x[OW-1:0];
      end
      return x[PW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
   endfunction

   pcpc_pkg::state_type state_ff, state_in;

   logic [pcpc_pkg::OFFSET_W-1:0]  offset_ff [3];
   logic [pcpc_pkg::GAIN_W-1:0]    cgain_ff;
   logic [pcpc_pkg::GAIN_W-1:0]    vgain_ff;
   logic [pcpc_pkg::ALPHA_W-1:0]   alpha_ff;

   logic [ADC-1:0]           first_ff [4];
   logic [ADC-1:0]           second_ff [4];
   logic                     pair_ff;
   logic signed [OW-1:0]     filt_ff [3];
   logic signed [CW-1:0]     cur_ff [3];
   logic signed [CW-1:0]     mean_ff;
   logic signed [OW-1:0]     delta_ff [3];
   logic [1:0]               ph_ff;
   logic signed [PW-1:0]     prod_ff;
   logic signed [PW-1:0]     acc_ff;
   logic                     sign_ff;
   logic [OW-1:0]            count_ff;
   logic [OW-1:0]            count_in;
   logic                     rsp_valid_ff;
   pcpc_pkg::rsp_type        rsp_data_ff;

   logic                     req_take;
   logic                     rsp_free;
   logic                     rsp_load;
   logic                     ph_adv;
   logic                     ph_last;
   pcpc_pkg::div_req_type    div_req;
   pcpc_pkg::div_rsp_type    div_rsp;

   logic [pcpc_pkg::ALPHA_W-1:0] alpha_eff;
   logic [pcpc_pkg::ALPHA_W-1:0] alpha_cmp;
   logic [ADC:0]                 pair_sum;
   logic signed [AVG_W-1:0]      avg_s;
   logic signed [ADC:0]          d_s [3];
   logic signed [DNUM_W-1:0]     d_sel;
   logic signed [DNUM_W-1:0]     dsum;
   logic signed [DNUM_W-1:0]     dnum;
   logic [ADC:0]                 vsum;
   logic signed [MW-1:0]         mul_a;
   logic signed [MW-1:0]         mul_b;
   logic signed [PW-1:0]         filt_rnd;
   logic signed [PW-1:0]         cur_rnd;
   logic signed [PW-1:0]         csum;
   logic [PW-1:0]                csum_mag;
   logic [PW-1:0]                prod_mag;
   logic [PW-1:0]                vbus_full;
   logic signed [PW-1:0]         quo_s;
   logic [OW-1:0]                vbus_sat;

   pcpc_div3 u_div3 (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign ph_last  = (ph_ff == 2'd2);
   assign req_take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcpc_pkg::ST_IDLE: begin
            if (req_valid && pair_ff) begin
               state_in = pcpc_pkg::ST_FILT_NEW;
            end
         end
         pcpc_pkg::ST_FILT_NEW:    state_in = pcpc_pkg::ST_FILT_OLD;
         pcpc_pkg::ST_FILT_OLD:    state_in = pcpc_pkg::ST_FILT_RND;
         pcpc_pkg::ST_FILT_RND:    state_in = pcpc_pkg::ST_GAIN_MUL;
         pcpc_pkg::ST_GAIN_MUL:    state_in = pcpc_pkg::ST_GAIN_RND;
         pcpc_pkg::ST_GAIN_RND: begin
            state_in = ph_last ? pcpc_pkg::ST_MEAN_START : pcpc_pkg::ST_FILT_NEW;
         end
         pcpc_pkg::ST_MEAN_START:  state_in = pcpc_pkg::ST_MEAN_WAIT;
         pcpc_pkg::ST_MEAN_WAIT: begin
            if (div_rsp.done) begin
               state_in = pcpc_pkg::ST_DELTA_MUL;
            end
         end
         pcpc_pkg::ST_DELTA_MUL:   state_in = pcpc_pkg::ST_DELTA_START;
         pcpc_pkg::ST_DELTA_START: state_in = pcpc_pkg::ST_DELTA_WAIT;
         pcpc_pkg::ST_DELTA_WAIT: begin
            if (div_rsp.done) begin
               state_in = ph_last ? pcpc_pkg::ST_VBUS_MUL : pcpc_pkg::ST_DELTA_MUL;
            end
         end
         pcpc_pkg::ST_VBUS_MUL:    state_in = pcpc_pkg::ST_OUTPUT;
         pcpc_pkg::ST_OUTPUT: begin
            if (rsp_free) begin
               state_in = pcpc_pkg::ST_IDLE;
            end
         end
         default:                  state_in = pcpc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == pcpc_pkg::ST_IDLE);
      div_req.start = (state_ff == pcpc_pkg::ST_MEAN_START) ||
                      (state_ff == pcpc_pkg::ST_DELTA_START);
      rsp_load      = (state_ff == pcpc_pkg::ST_OUTPUT) && rsp_free;
      ph_adv        = (state_ff == pcpc_pkg::ST_GAIN_RND) ||
                      ((state_ff == pcpc_pkg::ST_DELTA_WAIT) && div_rsp.done);
   end

   always_comb begin
      alpha_eff = (alpha_ff > pcpc_pkg::ALPHA_ONE) ? pcpc_pkg::ALPHA_ONE : alpha_ff;
      alpha_cmp = pcpc_pkg::ALPHA_ONE - alpha_eff;
      pair_sum  = {1'b0, first_ff[ph_ff]} + {1'b0, second_ff[ph_ff]};
      avg_s     = signed'({1'b0, pair_sum, 7'b0}) - signed'(AVG_W'(offset_ff[ph_ff]));
      for (int i = 0; i < 3; i++) begin
         d_s[i] = signed'({1'b0, second_ff[i]}) - signed'({1'b0, first_ff[i]});
      end
      unique case (ph_ff)
         2'd0:    d_sel = DNUM_W'(d_s[0]);
         2'd1:    d_sel = DNUM_W'(d_s[1]);
         default: d_sel = DNUM_W'(d_s[2]);
      endcase
      dsum = DNUM_W'(d_s[0]) + DNUM_W'(d_s[1]) + DNUM_W'(d_s[2]);
      dnum = (d_sel <<< 1) + d_sel - dsum;
      vsum = {1'b0, first_ff[3]} + {1'b0, second_ff[3]};
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pcpc_pkg::ST_FILT_NEW: begin
            mul_a = MW'(signed'({avg_s, 8'b0}));
            mul_b = signed'(MW'(alpha_eff));
         end
         pcpc_pkg::ST_FILT_OLD: begin
            mul_a = MW'(filt_ff[ph_ff]);
            mul_b = signed'(MW'(alpha_cmp));
         end
         pcpc_pkg::ST_GAIN_MUL: begin
            mul_a = MW'(filt_ff[ph_ff]);
            mul_b = signed'(MW'(cgain_ff));
         end
         pcpc_pkg::ST_DELTA_MUL: begin
            mul_a = MW'(dnum);
            mul_b = signed'(MW'(cgain_ff));
         end
         pcpc_pkg::ST_VBUS_MUL, pcpc_pkg::ST_OUTPUT: begin
            mul_a = signed'(MW'(vsum));
            mul_b = signed'(MW'(vgain_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      filt_rnd  = round_shift(acc_ff + prod_ff, pcpc_pkg::ALPHA_FRAC);
      cur_rnd   = round_shift(prod_ff, CUR_SH);
      csum      = PW'(cur_ff[0]) + PW'(cur_ff[1]) + PW'(cur_ff[2]);
      csum_mag  = csum[PW-1] ? PW'(-csum) : PW'(csum);
      prod_mag  = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      if (state_ff == pcpc_pkg::ST_MEAN_START) begin
         div_req.dividend = DW'(csum_mag + PW'(1));
      end else begin
         div_req.dividend = DW'((prod_mag + PW'(DELTA_HALF)) >> DELTA_SH);
      end
      quo_s     = sign_ff ? -signed'(PW'(div_rsp.quotient)) : signed'(PW'(div_rsp.quotient));
      vbus_full = (PW'(prod_ff) + (PW'(1) << (VBUS_SH - 1))) >> VBUS_SH;
      vbus_sat  = (|vbus_full[PW-1:OW]) ? '1 : vbus_full[OW-1:0];
      count_in  = count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcpc_pkg::ST_IDLE;
         offset_ff[0] <= pcpc_pkg::OFFSET_RESET;
         offset_ff[1] <= pcpc_pkg::OFFSET_RESET;
         offset_ff[2] <= pcpc_pkg::OFFSET_RESET;
         cgain_ff     <= pcpc_pkg::GAIN_RESET;
         vgain_ff     <= pcpc_pkg::GAIN_RESET;
         alpha_ff     <= pcpc_pkg::ALPHA_ONE;
         pair_ff      <= 1'b0;
         ph_ff        <= 2'd0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            first_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            filt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               pcpc_pkg::CSR_OFFSET_U:     offset_ff[0] <= csr_wdata[pcpc_pkg::OFFSET_W-1:0];
               pcpc_pkg::CSR_OFFSET_V:     offset_ff[1] <= csr_wdata[pcpc_pkg::OFFSET_W-1:0];
               pcpc_pkg::CSR_OFFSET_W:     offset_ff[2] <= csr_wdata[pcpc_pkg::OFFSET_W-1:0];
               pcpc_pkg::CSR_CURRENT_GAIN: cgain_ff     <= csr_wdata[pcpc_pkg::GAIN_W-1:0];
               pcpc_pkg::CSR_VOLTAGE_GAIN: vgain_ff     <= csr_wdata[pcpc_pkg::GAIN_W-1:0];
               pcpc_pkg::CSR_FILTER_ALPHA: alpha_ff     <= csr_wdata[pcpc_pkg::ALPHA_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_take) begin
            pair_ff <= !pair_ff;
            if (!pair_ff) begin
               first_ff[0] <= req_data.raw_u;
               first_ff[1] <= req_data.raw_v;
               first_ff[2] <= req_data.raw_w;
               first_ff[3] <= req_data.raw_vbus;
            end
         end
         if (state_ff == pcpc_pkg::ST_FILT_RND) begin
            filt_ff[ph_ff] <= sat32(filt_rnd);
         end
         if (ph_adv) begin
            ph_ff <= ph_last ? 2'd0 : ph_ff + 2'd1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            count_ff     <= count_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (req_take && pair_ff) begin
         second_ff[0] <= req_data.raw_u;
         second_ff[1] <= req_data.raw_v;
         second_ff[2] <= req_data.raw_w;
         second_ff[3] <= req_data.raw_vbus;
      end
      if (state_ff == pcpc_pkg::ST_FILT_OLD) begin
         acc_ff <= prod_ff;
      end
      if (state_ff == pcpc_pkg::ST_GAIN_RND) begin
         cur_ff[ph_ff] <= cur_rnd[CW-1:0];
      end
      if (state_ff == pcpc_pkg::ST_MEAN_START) begin
         sign_ff <= csum[PW-1];
      end
      if (state_ff == pcpc_pkg::ST_DELTA_START) begin
         sign_ff <= prod_ff[PW-1];
      end
      if ((state_ff == pcpc_pkg::ST_MEAN_WAIT) && div_rsp.done) begin
         mean_ff <= quo_s[CW-1:0];
      end
      if ((state_ff == pcpc_pkg::ST_DELTA_WAIT) && div_rsp.done) begin
         delta_ff[ph_ff] <= sat32(quo_s);
      end
      if (rsp_load) begin
         rsp_data_ff.current_u    <= sat32(PW'(cur_ff[0]) - PW'(mean_ff));
         rsp_data_ff.current_v    <= sat32(PW'(cur_ff[1]) - PW'(mean_ff));
         rsp_data_ff.current_w    <= sat32(PW'(cur_ff[2]) - PW'(mean_ff));
         rsp_data_ff.delta_u      <= delta_ff[0];
         rsp_data_ff.delta_v      <= delta_ff[1];
         rsp_data_ff.delta_w      <= delta_ff[2];
         rsp_data_ff.bus_voltage  <= vbus_sat;
         rsp_data_ff.update_count <= count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == pcpc_pkg::ST_MEAN_WAIT ||
                        state_ff == pcpc_pkg::ST_DELTA_WAIT))
      else $error("Divider finished outside a wait state.");

   a_phase_index_range: assert property (@(posedge clock) disable iff (reset)
      ph_ff != 2'd3)
      else $error("Phase index left its range.");

   a_second_beat_starts: assert property (@(posedge clock) disable iff (reset)
      (req_take && pair_ff) |=> (state_ff == pcpc_pkg::ST_FILT_NEW && !pair_ff))
      else $error("Second beat of a pair did not start the sequence.");

   a_phase_wrapped_at_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcpc_pkg::ST_OUTPUT) |-> (ph_ff == 2'd0))
      else $error("Phase index did not wrap before the output step.");

   a_count_matches_result: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && rsp_data_ff.update_count == count_ff))
      else $error("Result count and counter register disagree.");

endmodule
`default_nettype wire
